// ----- hw/rtl/osv_pkg.sv -----
// ----------------------------------------------------------------------------
// osv_pkg
// shared types and constants of the octant shadowcast visibility core
// ----------------------------------------------------------------------------
package osv_pkg;

  localparam int unsigned MaxIntervals = 16;
  localparam int unsigned MaxRadius    = 31;
  localparam int unsigned FractionBits = 16;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_VISIBLE  = 2'd0,
    ST_HIDDEN   = 2'd1,
    ST_SKIPPED  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DIV,
    FSM_COVER,
    FSM_SHIFT,
    FSM_OUT
  } fsm_e;

  typedef struct packed {
    logic [2:0] octant;
    logic [4:0] row;
    logic [4:0] col;
    logic       opaque;
    logic       clear_set;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] world_x;
    logic [15:0] world_y;
    logic        set_overflow;
  } out_req_t;

endpackage

// ----- hw/rtl/osv_stream_if.sv -----
// ----------------------------------------------------------------------------
// osv_stream_if
// valid/ready channel carrying one request payload
// ----------------------------------------------------------------------------
interface osv_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/osv_divider.sv -----
// ----------------------------------------------------------------------------
// osv_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module osv_divider #(
  parameter int unsigned NumW = 22,
  parameter int unsigned DenW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;
  logic            q_bit;

  assign trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign q_bit = (trial >= {1'b0, den_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = q_bit ? (trial - {1'b0, den_q}) : trial;
      quo_d = {quo_q[NumW-2:0], q_bit};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // final quotient is the last shift, independent of a new start
  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quo_o  = {quo_q[NumW-2:0], q_bit};
endmodule

// ----- hw/rtl/osv_cell.sv -----
// ----------------------------------------------------------------------------
// osv_cell
// one shadow interval slot; shifts toward its neighbor on insert or remove
// ----------------------------------------------------------------------------
module osv_cell #(
  parameter int unsigned SlopeW = 18
) (
  input  logic              clk_i,
  input  logic              valid_i,
  input  logic              upd_i,
  input  logic              prev_i,
  input  logic              next_i,
  input  logic [SlopeW-1:0] tlo_i,
  input  logic [SlopeW-1:0] thi_i,
  input  logic              left_lt_i,
  input  logic [SlopeW-1:0] left_lo_i,
  input  logic [SlopeW-1:0] left_hi_i,
  input  logic              right_lt_i,
  input  logic [SlopeW-1:0] right_lo_i,
  input  logic [SlopeW-1:0] right_hi_i,
  output logic [SlopeW-1:0] lo_o,
  output logic [SlopeW-1:0] hi_o,
  output logic              lt_o,
  output logic              cov_o,
  output logic              prev_hit_o,
  output logic              next_hit_o
);
  logic [SlopeW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [SlopeW-1:0] mlo, mhi, blo, bhi;
  logic              lt, ov, at_pos, at_prev;

  assign lt      = valid_i && (lo_q < tlo_i);
  assign ov      = valid_i && (hi_q >= tlo_i) && (thi_i >= lo_q);
  assign at_pos  = !lt && left_lt_i;
  assign at_prev = lt && !right_lt_i;

  assign mlo = (tlo_i < lo_q) ? tlo_i : lo_q;
  assign mhi = (thi_i > hi_q) ? thi_i : hi_q;
  assign blo = (right_lo_i < mlo) ? right_lo_i : mlo;
  assign bhi = (right_hi_i > mhi) ? right_hi_i : mhi;

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (upd_i) begin
      priority if (prev_i && next_i) begin
        if (at_prev) begin
          lo_d = blo;
          hi_d = bhi;
        end else if (!lt) begin
          lo_d = right_lo_i;
          hi_d = right_hi_i;
        end
      end else if (prev_i) begin
        if (at_prev) begin
          lo_d = mlo;
          hi_d = mhi;
        end
      end else if (next_i) begin
        if (at_pos) begin
          lo_d = mlo;
          hi_d = mhi;
        end
      end else begin
        if (at_pos) begin
          lo_d = tlo_i;
          hi_d = thi_i;
        end else if (!lt) begin
          lo_d = left_lo_i;
          hi_d = left_hi_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign lo_o       = lo_q;
  assign hi_o       = hi_q;
  assign lt_o       = lt;
  assign cov_o      = valid_i && (lo_q <= tlo_i) && (hi_q >= thi_i);
  assign prev_hit_o = at_prev && ov;
  assign next_hit_o = at_pos && ov;
endmodule

// ----- hw/rtl/octant_shadowcast_visibility_core.sv -----
// ----------------------------------------------------------------------------
// octant_shadowcast_visibility_core
// shadowcasting field of view for one octant, one tile per request
// ----------------------------------------------------------------------------
// usage: send tiles of an octant in row-major order on in_req; set
// clear_set on the first tile of each octant. each input request yields
// exactly one output request on out_req with status, world position and
// overflow flag. configuration (origin_x, origin_y, radius) is written on
// the cfg port while no tile is in flight.
// processing: two serial slope divisions of FRACTION_BITS+6 quotient bits
// each, then the parallel cover test in the cell chain, the set update and
// building the result in the output register. a new tile is taken only
// after the previous one has been built into a result; one tile is worked
// on at a time so the set is current for the next.
// reset empties the interval set and sets radius to 10 and the origin to 0.
// when the receiver stalls the result waits in the output register; the
// next tile is still taken and computed, then held until the register frees.
// ----------------------------------------------------------------------------
module octant_shadowcast_visibility_core
  import osv_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = MaxIntervals,
  parameter int unsigned MAX_RADIUS    = MaxRadius,
  parameter int unsigned FRACTION_BITS = FractionBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  osv_stream_if.sink          in_req,
  osv_stream_if.source        out_req
);
  localparam int unsigned SlopeW = FRACTION_BITS + 6;
  localparam int unsigned NumW   = FRACTION_BITS + 6;
  localparam int unsigned CntW   = $clog2(MAX_INTERVALS + 1);

  // configuration
  logic signed [14:0] org_x_q, org_y_q;
  logic [4:0]         radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q  <= '0;
      org_y_q  <= '0;
      radius_q <= 5'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_X: org_x_q  <= cfg_data_i;
        CFG_ORIGIN_Y: org_y_q  <= cfg_data_i;
        CFG_RADIUS:   radius_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // controller state
  fsm_e state_q, state_d;
  in_req_t tile_q;
  logic [CntW-1:0] count_q, count_d;
  logic            phase_q, phase_d;
  logic            covered_q, covered_d;
  logic            prev_q, prev_d, next_q, next_d;
  logic            ovf_q, ovf_d;
  logic [SlopeW-1:0] tlo_q, tlo_d, thi_q, thi_d;
  logic            out_valid_q, out_valid_d;
  out_req_t        out_q, out_d;
  logic            in_range;
  logic            upd;

  // divider
  logic            div_start, div_done;
  logic [NumW-1:0] div_num, div_quo;
  logic [5:0]      div_den;

  osv_divider #(.NumW(NumW), .DenW(6)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // cell chain: entries sorted by lower slope, the first count_q are valid
  logic [SlopeW-1:0] c_lo [MAX_INTERVALS];
  logic [SlopeW-1:0] c_hi [MAX_INTERVALS];
  logic [SlopeW-1:0] l_lo [MAX_INTERVALS];
  logic [SlopeW-1:0] l_hi [MAX_INTERVALS];
  logic [SlopeW-1:0] r_lo [MAX_INTERVALS];
  logic [SlopeW-1:0] r_hi [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] c_vld, c_lt, c_cov, c_ph, c_nh, l_lt, r_lt;

  for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
    assign c_vld[k] = (CntW'(k) < count_q);
    if (k == 0) begin : g_first
      assign l_lt[k] = 1'b1;
      assign l_lo[k] = c_lo[k];
      assign l_hi[k] = c_hi[k];
    end else begin : g_left
      assign l_lt[k] = c_lt[k-1];
      assign l_lo[k] = c_lo[k-1];
      assign l_hi[k] = c_hi[k-1];
    end
    if (k == MAX_INTERVALS - 1) begin : g_last
      assign r_lt[k] = 1'b0;
      assign r_lo[k] = c_lo[k];
      assign r_hi[k] = c_hi[k];
    end else begin : g_right
      assign r_lt[k] = c_lt[k+1];
      assign r_lo[k] = c_lo[k+1];
      assign r_hi[k] = c_hi[k+1];
    end
    osv_cell #(.SlopeW(SlopeW)) u_cell (
      .clk_i,
      .valid_i(c_vld[k]), .upd_i(upd), .prev_i(prev_q), .next_i(next_q),
      .tlo_i(tlo_q), .thi_i(thi_q),
      .left_lt_i(l_lt[k]), .left_lo_i(l_lo[k]), .left_hi_i(l_hi[k]),
      .right_lt_i(r_lt[k]), .right_lo_i(r_lo[k]), .right_hi_i(r_hi[k]),
      .lo_o(c_lo[k]), .hi_o(c_hi[k]), .lt_o(c_lt[k]), .cov_o(c_cov[k]),
      .prev_hit_o(c_ph[k]), .next_hit_o(c_nh[k])
    );
  end

  logic signed [15:0] dx, dy;
  logic [10:0] dist2;
  logic [10:0] rad2;

  always_comb begin
    unique case (tile_q.octant)
      3'd0: begin dx =  16'(tile_q.col); dy = -16'(tile_q.row); end
      3'd1: begin dx =  16'(tile_q.row); dy = -16'(tile_q.col); end
      3'd2: begin dx =  16'(tile_q.row); dy =  16'(tile_q.col); end
      3'd3: begin dx =  16'(tile_q.col); dy =  16'(tile_q.row); end
      3'd4: begin dx = -16'(tile_q.col); dy =  16'(tile_q.row); end
      3'd5: begin dx = -16'(tile_q.row); dy =  16'(tile_q.col); end
      3'd6: begin dx = -16'(tile_q.row); dy = -16'(tile_q.col); end
      default: begin dx = -16'(tile_q.col); dy = -16'(tile_q.row); end
    endcase
  end

  assign dist2 = 11'(tile_q.col) * 11'(tile_q.col) + 11'(tile_q.row) * 11'(tile_q.row);
  assign rad2  = 11'(radius_q) * 11'(radius_q);
  assign in_range = (tile_q.row != 5'd0) && (tile_q.col <= tile_q.row) &&
                    (tile_q.row < radius_q) && (32'(tile_q.row) < MAX_RADIUS) &&
                    (dist2 <= rad2);

  assign in_req.ready  = (state_q == FSM_IDLE);
  assign out_req.valid = out_valid_q;
  assign out_req.data  = out_q;

  always_comb begin
    state_d = state_q;     count_d = count_q;   phase_d = phase_q;
    covered_d = covered_q; prev_d = prev_q;     next_d = next_q;
    ovf_d = ovf_q;         tlo_d = tlo_q;       thi_d = thi_q;
    out_valid_d = out_valid_q; out_d = out_q;
    div_start = 1'b0;
    div_num = '0; div_den = '0;
    upd = 1'b0;
    if (out_req.valid && out_req.ready) out_valid_d = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_req.valid && in_req.ready) begin
          if (in_req.data.clear_set) count_d = '0;
          div_start = 1'b1;
          div_num = NumW'(in_req.data.col) << FRACTION_BITS;
          div_den = 6'(in_req.data.row) + 6'd1;
          phase_d = 1'b0;
          state_d = FSM_DIV;
        end
      end
      FSM_DIV: begin
        if (div_done) begin
          if (!phase_q) begin
            tlo_d = div_quo;
            div_start = 1'b1;
            div_num = NumW'(6'(tile_q.col) + 6'd1) << FRACTION_BITS;
            div_den = 6'(tile_q.row);
            phase_d = 1'b1;
          end else begin
            thi_d = div_quo;
            state_d = FSM_COVER;
          end
        end
      end
      // every cell checks its entry against the tile in parallel
      FSM_COVER: begin
        covered_d = |c_cov;
        prev_d = |c_ph;
        next_d = |c_nh;
        state_d = FSM_SHIFT;
      end
      // merge, insert or drop the opaque interval
      FSM_SHIFT: begin
        ovf_d = 1'b0;
        if (in_range && !covered_q && tile_q.opaque) begin
          if (prev_q && next_q) begin
            upd = 1'b1;
            count_d = count_q - CntW'(1);
          end else if (prev_q || next_q) begin
            upd = 1'b1;
          end else if (count_q == CntW'(MAX_INTERVALS)) begin
            ovf_d = 1'b1;
          end else begin
            upd = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        state_d = FSM_OUT;
      end
      FSM_OUT: begin
        if (!out_valid_q || out_req.ready) begin
          out_d.world_x = {org_x_q[14], org_x_q} + dx;
          out_d.world_y = {org_y_q[14], org_y_q} + dy;
          out_d.set_overflow = ovf_q;
          if (!in_range) out_d.status = ST_SKIPPED;
          else if (covered_q)
            out_d.status = (!tile_q.octant[0] && (tile_q.col == 5'd0 ||
                            tile_q.col == tile_q.row)) ? ST_SKIPPED : ST_HIDDEN;
          else out_d.status = ST_VISIBLE;
          out_valid_d = 1'b1;
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      count_q <= '0;
      out_valid_q <= 1'b0;
      tile_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      out_valid_q <= out_valid_d;
      if (in_req.valid && in_req.ready) tile_q <= in_req.data;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d; covered_q <= covered_d;
    prev_q <= prev_d; next_q <= next_d; ovf_q <= ovf_d;
    tlo_q <= tlo_d; thi_q <= thi_d;
    out_q <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_INTERVALS)) else $error("interval count overflow");
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req.valid && in_req.ready) |=> !in_req.ready) else $error("second tile taken");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_req.valid && !out_req.ready) |=> out_req.valid) else $error("result lost");
`endif
endmodule
